/* rtl/apcl_pkg.sv */
`timescale 1ns / 1ps

package apcl_pkg;

   // window length and state widths
   localparam int SAMPLES_PER_UPDATE = 16;
   localparam int SampleWidth        = 12;
   localparam int SumWidth           = 22;
   localparam int CountWidth         = 10;
   localparam int DiffWidth          = SampleWidth + 1;
   localparam int GainWidth          = 24;
   localparam int AmpsWidth          = 37;
   localparam int ErrWidth           = 38;
   localparam int IntegWidth         = 40;
   localparam int DutyWidth          = 50;
   localparam int AccWidth           = 64;
   localparam int MulBWidth          = 21;
   localparam int ProdWidth          = GainWidth + 1 + MulBWidth;
   localparam int ChunkShift         = 20;
   localparam int FracBits           = 16;

   // duty limits in Q16
   localparam logic signed [DutyWidth-1:0] DutyZero = 50'sd0;
   localparam logic signed [DutyWidth-1:0] DutyHalf = 50'sd32768;
   localparam logic signed [DutyWidth-1:0] DutyOne  = 50'sd65536;
   localparam logic signed [DutyWidth-1:0] DutyMin  = 50'sd655;
   localparam logic signed [DutyWidth-1:0] DutyMax  = 50'sd64881;

   // register reset values
   localparam logic [11:0] SetpointZeroReset = 12'd1965;
   localparam logic [11:0] CurrentZeroReset  = 12'd2565;
   localparam logic [15:0] TimerPeriodReset  = 16'hFFFF;

   // configuration register indexes
   typedef enum logic [3:0] {
      CSR_SETPOINT_ZERO = 4'd0,
      CSR_CURRENT_ZERO  = 4'd1,
      CSR_SETPOINT_GAIN = 4'd2,
      CSR_CURRENT_GAIN  = 4'd3,
      CSR_PROP_GAIN     = 4'd4,
      CSR_INTEGRAL_GAIN = 4'd5,
      CSR_DIRECT_GAIN   = 4'd6,
      CSR_TIMER_PERIOD  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [11:0]          setpoint_zero;
      logic [11:0]          current_zero;
      logic [GainWidth-1:0] setpoint_gain;
      logic [GainWidth-1:0] current_gain;
      logic [GainWidth-1:0] prop_gain;
      logic [GainWidth-1:0] integral_gain;
      logic [GainWidth-1:0] direct_gain;
      logic [15:0]          timer_period;
   } cfg_type;

   // one completed window handed from front to back
   typedef struct packed {
      logic signed [DiffWidth-1:0] sp_diff;
      logic signed [DiffWidth-1:0] cur_diff;
      logic                        pi_mode;
      logic                        bridge_disable;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SP,
      ST_CUR,
      ST_P_LO,
      ST_P_HI,
      ST_I_LO,
      ST_I_HI,
      ST_I_END,
      ST_D_LO,
      ST_D_HI,
      ST_D_END,
      ST_DECIDE,
      ST_TIMER,
      ST_OUT
   } back_state_type;

endpackage

/* rtl/apcl_if.sv */
`timescale 1ns / 1ps

// sample channel
interface apcl_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] current_sample;
   logic [11:0] setpoint_sample;
   logic        pi_mode;
   logic        bridge_disable;

   modport source (output valid, current_sample, setpoint_sample, pi_mode, bridge_disable,
                   input ready);
   modport sink (input valid, current_sample, setpoint_sample, pi_mode, bridge_disable,
                 output ready);
endinterface

// result channel
interface apcl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] compare_value;
   logic [11:0] dac_code;
   logic [15:0] duty_q16;
   logic        bridge_enable;

   modport source (output valid, compare_value, dac_code, duty_q16, bridge_enable,
                   input ready);
   modport sink (input valid, compare_value, dac_code, duty_q16, bridge_enable,
                 output ready);
endinterface

// register write channel
interface apcl_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/apcl_csr.sv */
`timescale 1ns / 1ps

module apcl_csr (
   input  logic                clock,
   input  logic                reset,
   apcl_csr_if.sink            csr_bus,
   output apcl_pkg::cfg_type   cfg
);

   apcl_pkg::cfg_type cfg_ff;
   apcl_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   // register decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            apcl_pkg::CSR_SETPOINT_ZERO: cfg_in.setpoint_zero = csr_bus.data[11:0];
            apcl_pkg::CSR_CURRENT_ZERO:  cfg_in.current_zero  = csr_bus.data[11:0];
            apcl_pkg::CSR_SETPOINT_GAIN: cfg_in.setpoint_gain = csr_bus.data;
            apcl_pkg::CSR_CURRENT_GAIN:  cfg_in.current_gain  = csr_bus.data;
            apcl_pkg::CSR_PROP_GAIN:     cfg_in.prop_gain     = csr_bus.data;
            apcl_pkg::CSR_INTEGRAL_GAIN: cfg_in.integral_gain = csr_bus.data;
            apcl_pkg::CSR_DIRECT_GAIN:   cfg_in.direct_gain   = csr_bus.data;
            apcl_pkg::CSR_TIMER_PERIOD:  cfg_in.timer_period  = csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint_zero <= apcl_pkg::SetpointZeroReset;
         cfg_ff.current_zero  <= apcl_pkg::CurrentZeroReset;
         cfg_ff.setpoint_gain <= '0;
         cfg_ff.current_gain  <= '0;
         cfg_ff.prop_gain     <= '0;
         cfg_ff.integral_gain <= '0;
         cfg_ff.direct_gain   <= '0;
         cfg_ff.timer_period  <= apcl_pkg::TimerPeriodReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/apcl_front.sv */
`timescale 1ns / 1ps

module apcl_front (
   input  logic                clock,
   input  logic                reset,
   apcl_req_if.sink            req_bus,
   input  apcl_pkg::cfg_type   cfg,
   input  logic                job_full,
   output logic                job_push,
   output apcl_pkg::job_type   job_data
);

   localparam logic [apcl_pkg::CountWidth-1:0] LastCount =
      apcl_pkg::CountWidth'(apcl_pkg::SAMPLES_PER_UPDATE - 1);

   logic [apcl_pkg::SumWidth-1:0]   cur_sum_ff, cur_sum_in;
   logic [apcl_pkg::SumWidth-1:0]   sp_sum_ff, sp_sum_in;
   logic [apcl_pkg::CountWidth-1:0] count_ff, count_in;
   logic [apcl_pkg::SumWidth-1:0]   cur_total, sp_total;
   logic [11:0]                     cur_mean, sp_mean;
   logic                            window_end;
   logic                            accept;

   assign window_end    = (count_ff == LastCount);
   // stall only when a finished window has nowhere to go
   assign req_bus.ready = !(window_end && job_full);
   assign accept        = req_bus.valid && req_bus.ready;

   assign cur_total = cur_sum_ff + apcl_pkg::SumWidth'(req_bus.current_sample);
   assign sp_total  = sp_sum_ff + apcl_pkg::SumWidth'(req_bus.setpoint_sample);
   assign cur_mean  = 12'(cur_total / apcl_pkg::SAMPLES_PER_UPDATE);
   assign sp_mean   = 12'(sp_total / apcl_pkg::SAMPLES_PER_UPDATE);

   // offset-corrected means of the window
   assign job_push                = accept && window_end;
   assign job_data.sp_diff        = $signed({1'b0, sp_mean}) - $signed({1'b0, cfg.setpoint_zero});
   assign job_data.cur_diff       = $signed({1'b0, cur_mean}) - $signed({1'b0, cfg.current_zero});
   assign job_data.pi_mode        = req_bus.pi_mode;
   assign job_data.bridge_disable = req_bus.bridge_disable;

   // window accumulation
   always_comb begin
      cur_sum_in = cur_sum_ff;
      sp_sum_in  = sp_sum_ff;
      count_in   = count_ff;
      if (accept) begin
         if (window_end) begin
            cur_sum_in = '0;
            sp_sum_in  = '0;
            count_in   = '0;
         end else begin
            cur_sum_in = cur_total;
            sp_sum_in  = sp_total;
            count_in   = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_sum_ff <= '0;
         sp_sum_ff  <= '0;
         count_ff   <= '0;
      end else begin
         cur_sum_ff <= cur_sum_in;
         sp_sum_ff  <= sp_sum_in;
         count_ff   <= count_in;
      end
   end

endmodule

/* rtl/apcl_fifo.sv */
`timescale 1ns / 1ps

module apcl_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  apcl_pkg::job_type   push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output apcl_pkg::job_type   head
);

   apcl_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

   // two-entry job queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/apcl_back.sv */
`timescale 1ns / 1ps

module apcl_back (
   input  logic                clock,
   input  logic                reset,
   input  apcl_pkg::cfg_type   cfg,
   input  logic                job_valid,
   input  apcl_pkg::job_type   job,
   output logic                job_pop,
   apcl_rsp_if.source          rsp_bus
);

   localparam logic signed [apcl_pkg::IntegWidth:0] IntegMax =
      (apcl_pkg::IntegWidth + 1)'((64'sd1 <<< (apcl_pkg::IntegWidth - 1)) - 64'sd1);
   localparam logic signed [apcl_pkg::IntegWidth:0] IntegMin =
      (apcl_pkg::IntegWidth + 1)'(-(64'sd1 <<< (apcl_pkg::IntegWidth - 1)));

   apcl_pkg::back_state_type state_ff, state_in;

   logic signed [apcl_pkg::ProdWidth-1:0]  prod_ff, prod_in;
   logic signed [apcl_pkg::AmpsWidth-1:0]  sp_amps_ff, sp_amps_in;
   logic signed [apcl_pkg::ErrWidth-1:0]   err_ff, err_in;
   logic signed [apcl_pkg::AccWidth-1:0]   acc_ff, acc_in;
   logic signed [apcl_pkg::DutyWidth-1:0]  duty_ff, duty_in;
   logic [15:0]                            duty_c_ff, duty_c_in;
   logic signed [apcl_pkg::IntegWidth-1:0] integ_ff, integ_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]                            compare_ff, compare_in;
   logic [11:0]                            dac_ff, dac_in;
   logic [15:0]                            duty_out_ff, duty_out_in;
   logic                                   enable_ff, enable_in;

   logic                                   mul_en;
   logic [apcl_pkg::GainWidth-1:0]         mul_a;
   logic signed [apcl_pkg::MulBWidth-1:0]  mul_b;
   logic signed [apcl_pkg::AccWidth-1:0]   full_prod;
   logic signed [apcl_pkg::DutyWidth-1:0]  prod_term;
   logic signed [apcl_pkg::IntegWidth:0]   integ_sum;
   logic [27:0]                            dac_prod;
   logic                                   out_free;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.compare_value = compare_ff;
   assign rsp_bus.dac_code      = dac_ff;
   assign rsp_bus.duty_q16      = duty_out_ff;
   assign rsp_bus.bridge_enable = enable_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // shared multiplier: unsigned gain or timer period times signed chunk, registered
   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   // high chunk product joins the low one, then floor to Q16
   assign full_prod = acc_ff + (apcl_pkg::AccWidth'(prod_ff) <<< apcl_pkg::ChunkShift);
   assign prod_term = apcl_pkg::DutyWidth'($signed(full_prod[apcl_pkg::AccWidth-1:
                                                             apcl_pkg::FracBits]));

   assign integ_sum = apcl_pkg::IntegWidth'(0) + (apcl_pkg::IntegWidth + 1)'(integ_ff)
                      + (apcl_pkg::IntegWidth + 1)'(err_ff);

   // duty times 4095 as shift and subtract
   assign dac_prod = {duty_c_ff, 12'b0} - {12'b0, duty_c_ff};

   // control law sequencer
   always_comb begin
      state_in     = state_ff;
      sp_amps_in   = sp_amps_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      duty_in      = duty_ff;
      duty_c_in    = duty_c_ff;
      integ_in     = integ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      compare_in   = compare_ff;
      dac_in       = dac_ff;
      duty_out_in  = duty_out_ff;
      enable_in    = enable_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      job_pop      = 1'b0;

      case (state_ff)
         apcl_pkg::ST_IDLE: begin
            if (job_valid) begin
               mul_en   = 1'b1;
               mul_a    = cfg.setpoint_gain;
               mul_b    = apcl_pkg::MulBWidth'(job.sp_diff);
               state_in = apcl_pkg::ST_SP;
            end
         end
         apcl_pkg::ST_SP: begin
            sp_amps_in = prod_ff[apcl_pkg::AmpsWidth-1:0];
            mul_en     = 1'b1;
            mul_a      = cfg.current_gain;
            mul_b      = apcl_pkg::MulBWidth'(job.cur_diff);
            state_in   = apcl_pkg::ST_CUR;
         end
         apcl_pkg::ST_CUR: begin
            err_in = apcl_pkg::ErrWidth'(sp_amps_ff)
                     - apcl_pkg::ErrWidth'($signed(prod_ff[apcl_pkg::AmpsWidth-1:0]));
            state_in = job.pi_mode ? apcl_pkg::ST_P_LO : apcl_pkg::ST_D_LO;
         end
         // proportional term, two chunks
         apcl_pkg::ST_P_LO: begin
            mul_en   = 1'b1;
            mul_a    = cfg.prop_gain;
            mul_b    = $signed({1'b0, err_ff[apcl_pkg::ChunkShift-1:0]});
            state_in = apcl_pkg::ST_P_HI;
         end
         apcl_pkg::ST_P_HI: begin
            acc_in   = apcl_pkg::AccWidth'(prod_ff);
            mul_en   = 1'b1;
            mul_a    = cfg.prop_gain;
            mul_b    = apcl_pkg::MulBWidth'($signed(
                          err_ff[apcl_pkg::ErrWidth-1:apcl_pkg::ChunkShift]));
            state_in = apcl_pkg::ST_I_LO;
         end
         // integral term with the integrator before this update
         apcl_pkg::ST_I_LO: begin
            duty_in  = apcl_pkg::DutyHalf + prod_term;
            mul_en   = 1'b1;
            mul_a    = cfg.integral_gain;
            mul_b    = $signed({1'b0, integ_ff[apcl_pkg::ChunkShift-1:0]});
            state_in = apcl_pkg::ST_I_HI;
         end
         apcl_pkg::ST_I_HI: begin
            acc_in   = apcl_pkg::AccWidth'(prod_ff);
            mul_en   = 1'b1;
            mul_a    = cfg.integral_gain;
            mul_b    = apcl_pkg::MulBWidth'($signed(
                          integ_ff[apcl_pkg::IntegWidth-1:apcl_pkg::ChunkShift]));
            state_in = apcl_pkg::ST_I_END;
         end
         apcl_pkg::ST_I_END: begin
            duty_in  = duty_ff + prod_term;
            state_in = apcl_pkg::ST_DECIDE;
         end
         // direct drive term
         apcl_pkg::ST_D_LO: begin
            mul_en   = 1'b1;
            mul_a    = cfg.direct_gain;
            mul_b    = $signed({1'b0, sp_amps_ff[apcl_pkg::ChunkShift-1:0]});
            state_in = apcl_pkg::ST_D_HI;
         end
         apcl_pkg::ST_D_HI: begin
            acc_in   = apcl_pkg::AccWidth'(prod_ff);
            mul_en   = 1'b1;
            mul_a    = cfg.direct_gain;
            mul_b    = apcl_pkg::MulBWidth'($signed(
                          sp_amps_ff[apcl_pkg::AmpsWidth-1:apcl_pkg::ChunkShift]));
            state_in = apcl_pkg::ST_D_END;
         end
         apcl_pkg::ST_D_END: begin
            duty_in  = prod_term;
            state_in = apcl_pkg::ST_DECIDE;
         end
         // conditional integration and clamp
         apcl_pkg::ST_DECIDE: begin
            if (duty_ff > apcl_pkg::DutyZero && duty_ff < apcl_pkg::DutyOne) begin
               if (integ_sum > IntegMax) begin
                  integ_in = apcl_pkg::IntegWidth'(IntegMax);
               end else if (integ_sum < IntegMin) begin
                  integ_in = apcl_pkg::IntegWidth'(IntegMin);
               end else begin
                  integ_in = apcl_pkg::IntegWidth'(integ_sum);
               end
            end
            if (duty_ff > apcl_pkg::DutyMax) begin
               duty_c_in = 16'(apcl_pkg::DutyMax);
            end else if (duty_ff < apcl_pkg::DutyMin) begin
               duty_c_in = 16'(apcl_pkg::DutyMin);
            end else begin
               duty_c_in = duty_ff[15:0];
            end
            state_in = apcl_pkg::ST_TIMER;
         end
         apcl_pkg::ST_TIMER: begin
            mul_en   = 1'b1;
            mul_a    = apcl_pkg::GainWidth'(cfg.timer_period);
            mul_b    = $signed({5'b0, duty_c_ff});
            state_in = apcl_pkg::ST_OUT;
         end
         // hand the result to the output register
         apcl_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               compare_in   = prod_ff[31:16];
               dac_in       = dac_prod[27:16];
               duty_out_in  = duty_c_ff;
               enable_in    = !job.bridge_disable;
               job_pop      = 1'b1;
               state_in     = apcl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apcl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apcl_pkg::ST_IDLE;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      sp_amps_ff  <= sp_amps_in;
      err_ff      <= err_in;
      acc_ff      <= acc_in;
      duty_ff     <= duty_in;
      duty_c_ff   <= duty_c_in;
      compare_ff  <= compare_in;
      dac_ff      <= dac_in;
      duty_out_ff <= duty_out_in;
      enable_ff   <= enable_in;
   end

endmodule

/* rtl/averaged_pi_current_loop_pwm_core.sv */
`timescale 1ns / 1ps
// Samples are taken one per cycle, unless a window-closing sample meets a full job queue.
// The result of a window reaches the output register once the back end has handled it.
// The back end runs one window at a time through a single 25x21 multiplier, with more
// states in PI mode than in direct mode, and waits while the output stalls; a two-entry
// job queue lets the front keep taking samples. Synchronous active-high reset clears
// sums, count, integrator, queue and output valid, and loads cfg with its reset values.

module averaged_pi_current_loop_pwm_core (
   input  logic        clock,
   input  logic        reset,
   apcl_req_if.sink    req_bus,
   apcl_rsp_if.source  rsp_bus,
   apcl_csr_if.sink    csr_bus
);

   apcl_pkg::cfg_type cfg;
   apcl_pkg::job_type push_data;
   apcl_pkg::job_type head;
   logic              push;
   logic              full;
   logic              pop;
   logic              head_valid;

   // configuration registers
   apcl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // sample accumulation and window means
   apcl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg),
      .job_full (full),
      .job_push (push),
      .job_data (push_data)
   );

   // queue of finished windows
   apcl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // control law and output stage
   apcl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (head_valid),
      .job       (head),
      .job_pop   (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
